>>> rtl/pph_pkg.sv
package pph_pkg;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_FLAG1,
    PH_FLAG2,
    PH_OPTLEN,
    PH_OPT,
    PH_DATA
  } parse_phase_t;

  // reported phase codes
  localparam logic [1:0] OUT_HUNT   = 2'd0;
  localparam logic [1:0] OUT_FIXED  = 2'd1;
  localparam logic [1:0] OUT_OPT    = 2'd2;
  localparam logic [1:0] OUT_DATA   = 2'd3;

  // configuration register indexes
  localparam logic CFG_ID_LOW  = 1'b0;
  localparam logic CFG_ID_HIGH = 1'b1;

  localparam logic [31:0] ID_LOW_RESET  = 32'h0000_01E0;
  localparam logic [31:0] ID_HIGH_RESET = 32'h0000_01EF;

  localparam int unsigned PTS_STORE = 5;
  localparam logic [7:0]  PTS_MASK_HI  = 8'h0E;
  localparam logic [7:0]  PTS_MASK_MID = 8'hFE;

  // ticks / 90 = (ticks >> 1) / 45; floor(2^37 / 45)
  localparam logic [31:0] RECIP_45  = 32'd3054198966;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam logic [32:0] DIV_HALF  = 33'd45;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        packet_end;
    logic [1:0]  phase;
    logic        pts_valid;
    logic [32:0] pts_ticks;
  } result_t;

endpackage

>>> rtl/pph_parser.sv
module pph_parser
  import pph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        a_valid,
  output result_t     a_result,
  input  logic        a_stall
);

  logic [31:0]  id_low;
  logic [31:0]  id_high;
  logic [31:0]  sync_shift;
  logic [31:0]  sync_shift_next;
  parse_phase_t parse_phase;
  parse_phase_t parse_phase_next;
  logic [16:0]  bytes_left;
  logic [16:0]  bytes_left_next;
  logic [16:0]  left_dec;
  logic         used_up;
  logic [7:0]   opt_left;
  logic [7:0]   opt_left_next;
  logic [2:0]   opt_index;
  logic [2:0]   opt_index_next;
  logic [7:0]   pts_bytes [PTS_STORE];
  logic [7:0]   pts_bytes_next [PTS_STORE];
  logic         has_pts;
  logic         has_pts_next;
  result_t      res;
  logic         accept;

  assign in_stall = a_valid && a_stall;
  assign accept   = in_valid && !in_stall;

  assign left_dec = (bytes_left != 17'd0) ? bytes_left - 17'd1 : 17'd0;
  assign used_up  = (left_dec == 17'd0);

  always_comb begin
    sync_shift_next  = sync_shift;
    parse_phase_next = parse_phase;
    bytes_left_next  = bytes_left;
    opt_left_next    = opt_left;
    opt_index_next   = opt_index;
    pts_bytes_next   = pts_bytes;
    has_pts_next     = has_pts;
    res              = '0;
    unique case (parse_phase)
      PH_HUNT: begin
        res.phase       = OUT_HUNT;
        sync_shift_next = {sync_shift[23:0], data_byte};
        if (sync_shift_next >= id_low && sync_shift_next <= id_high) begin
          parse_phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        res.phase        = OUT_FIXED;
        bytes_left_next  = {1'b0, data_byte, 8'd0};
        parse_phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        res.phase        = OUT_FIXED;
        bytes_left_next  = bytes_left + {9'd0, data_byte};
        parse_phase_next = PH_FLAG1;
      end
      PH_FLAG1, PH_FLAG2: begin
        res.phase       = OUT_FIXED;
        bytes_left_next = left_dec;
        if (used_up) begin
          res.packet_end   = 1'b1;
          parse_phase_next = PH_HUNT;
        end else begin
          parse_phase_next = (parse_phase == PH_FLAG1) ? PH_FLAG2 : PH_OPTLEN;
        end
      end
      PH_OPTLEN: begin
        res.phase       = OUT_FIXED;
        opt_left_next   = data_byte;
        opt_index_next  = 3'd0;
        has_pts_next    = (data_byte != 8'd0);
        bytes_left_next = left_dec;
        if (used_up) begin
          res.packet_end   = 1'b1;
          parse_phase_next = PH_HUNT;
        end else begin
          parse_phase_next = (data_byte != 8'd0) ? PH_OPT : PH_DATA;
        end
      end
      PH_OPT: begin
        res.phase = OUT_OPT;
        // bytes past the fifth are counted but dropped
        if (opt_index < 3'(PTS_STORE)) begin
          pts_bytes_next[opt_index] = data_byte;
          opt_index_next            = opt_index + 3'd1;
        end
        opt_left_next   = opt_left - 8'd1;
        bytes_left_next = left_dec;
        if (used_up) begin
          res.packet_end   = 1'b1;
          parse_phase_next = PH_HUNT;
        end else if (opt_left_next == 8'd0) begin
          parse_phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        res.phase         = OUT_DATA;
        res.payload_byte  = data_byte;
        res.payload_valid = 1'b1;
        bytes_left_next   = left_dec;
        if (used_up) begin
          res.packet_end   = 1'b1;
          parse_phase_next = PH_HUNT;
        end
      end
    endcase
    res.pts_valid = has_pts_next;
    res.pts_ticks = {pts_bytes_next[0][3:1] & PTS_MASK_HI[3:1],
                     pts_bytes_next[1],
                     pts_bytes_next[2][7:1] & PTS_MASK_MID[7:1],
                     pts_bytes_next[3],
                     pts_bytes_next[4][7:1] & PTS_MASK_MID[7:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_low  <= ID_LOW_RESET;
      id_high <= ID_HIGH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ID_LOW:  id_low  <= cfg_data;
        CFG_ID_HIGH: id_high <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_shift  <= '0;
      parse_phase <= PH_HUNT;
      bytes_left  <= '0;
      opt_left    <= '0;
      opt_index   <= '0;
      has_pts     <= 1'b0;
      for (int i = 0; i < PTS_STORE; i++) begin
        pts_bytes[i] <= '0;
      end
    end else if (accept) begin
      sync_shift  <= sync_shift_next;
      parse_phase <= parse_phase_next;
      bytes_left  <= bytes_left_next;
      opt_left    <= opt_left_next;
      opt_index   <= opt_index_next;
      has_pts     <= has_pts_next;
      pts_bytes   <= pts_bytes_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!in_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_result <= res;
    end
  end

endmodule

>>> rtl/pph_div90.sv
module pph_div90
  import pph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        a_valid,
  input  result_t     a_result,
  output logic        a_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output result_t     out_result,
  output logic [26:0] out_ms
);

  logic        b_valid;
  result_t     b_result;
  logic [31:0] b_half;
  logic [26:0] b_quot;
  logic [63:0] prod;
  logic        out_adv;
  logic        b_adv;
  logic [32:0] rem;
  logic [26:0] quot;

  assign out_adv = !out_valid || !out_stall;
  assign b_adv   = !b_valid || out_adv;
  assign a_stall = !b_adv;

  // estimate is exact or one short
  assign prod = {32'd0, a_result.pts_ticks[32:1]} * {32'd0, RECIP_45};

  assign rem  = {1'b0, b_half} - ({6'd0, b_quot} * DIV_HALF);
  assign quot = (rem >= DIV_HALF) ? b_quot + 27'd1 : b_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_adv) begin
        b_valid <= a_valid;
      end
      if (out_adv) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_valid) begin
      b_result <= a_result;
      b_half   <= a_result.pts_ticks[32:1];
      b_quot   <= prod[RECIP_SHIFT +: 27];
    end
    if (out_adv && b_valid) begin
      out_result <= b_result;
      out_ms     <= quot;
    end
  end

endmodule

>>> rtl/pes_packet_header_parser.sv
// pes packet header parser
// takes one stream byte per request on the input channel (in_valid / in_stall,
// data_byte) and returns exactly one result per byte on the output channel
// (out_valid / out_stall): payload byte and flag, packet end, parse phase,
// pts flag, pts in 90 kHz ticks and in milliseconds.
// the start code range is set through the write channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data): index 0 is the low bound, 1 the high bound;
// cfg_ready is always high. write only while the block is idle.
// the edge that takes a byte loads the parse register, then the result moves
// on to the reciprocal multiply register and then to the correction/output
// register, which drives out_valid and the outputs. throughput: one byte per
// cycle while the receiver does not stall, set by the parse step that updates
// the header state. when the receiver stalls, the output holds and the
// pipeline fills; empty stages still advance, so in_stall rises only once every
// stage is full.
// reset (synchronous) empties the pipeline, returns the parser to hunting,
// clears the pts bytes and restores the default start code range.
module pes_packet_header_parser
  import pph_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        packet_end,
  output logic [1:0]  phase,
  output logic        pts_valid,
  output logic [32:0] pts_ticks,
  output logic [26:0] pts_ms
);

  logic    a_valid;
  logic    a_stall;
  result_t a_result;
  result_t out_result;

  assign cfg_ready = 1'b1;

  pph_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .a_valid   (a_valid),
    .a_result  (a_result),
    .a_stall   (a_stall)
  );

  pph_div90 u_div90 (
    .clk        (clk),
    .rst        (rst),
    .a_valid    (a_valid),
    .a_result   (a_result),
    .a_stall    (a_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .out_ms     (pts_ms)
  );

  assign payload_byte  = out_result.payload_byte;
  assign payload_valid = out_result.payload_valid;
  assign packet_end    = out_result.packet_end;
  assign phase         = out_result.phase;
  assign pts_valid     = out_result.pts_valid;
  assign pts_ticks     = out_result.pts_ticks;

endmodule

>>> verif/pes_packet_header_parser_test.sv
`timescale 1ns / 1ps

module pes_packet_header_parser_test
  import pph_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_LINES = 50;

  // opening stream: a zero-length packet, then one with a full optional header
  localparam logic [183:0] OPENING = {56'h000001E00000FF,
                                      128'h000001EF000A80C005FFFFFFFFFF00FF};

  typedef struct packed {
    parse_phase_t     ph;
    logic [31:0]      sync;
    logic [16:0]      left;
    logic [7:0]       opt_left;
    logic [2:0]       opt_idx;
    logic [4:0][7:0]  pts;
    logic             pts_flag;
  } parser_state_t;

  typedef struct packed {
    logic [7:0]  pay_byte;
    logic        pay_valid;
    logic        pkt_end;
    logic [1:0]  ph_code;
    logic        pts_flag;
    logic [32:0] ticks;
    logic [26:0] ms;
  } byte_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_ID_LOW;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        packet_end;
  logic [1:0]  phase;
  logic        pts_valid;
  logic [32:0] pts_ticks;
  logic [26:0] pts_ms;

  logic [7:0]    stream_bytes[$];
  byte_result_t  parse_results_due[$];
  logic [7:0]    start_plan[$];

  parser_state_t chk_st;
  parser_state_t gen_st;
  logic [31:0]   chk_lo, chk_hi;
  logic [31:0]   gen_lo, gen_hi;

  int   mismatch_count = 0;
  int   cycle_count = 0;
  logic byte_taken = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  bit   receiver_busy = 1'b0;
  int   hold_left = 0;

  pes_packet_header_parser DUT (.*);

  always #6 clk = ~clk;

  function automatic bit length_spent(inout parser_state_t st);
    if (st.left != 0)
      st.left = st.left - 17'd1;
    return st.left == 0;
  endfunction

  function automatic byte_result_t parse_stream_byte(inout parser_state_t st,
                                                     input logic [31:0] lo,
                                                     input logic [31:0] hi,
                                                     input logic [7:0] b);
    byte_result_t r;
    r = '0;
    case (st.ph)
      PH_HUNT: begin
        r.ph_code = OUT_HUNT;
        st.sync = {st.sync[23:0], b};
        if (st.sync >= lo && st.sync <= hi)
          st.ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        r.ph_code = OUT_FIXED;
        st.left = {1'b0, b, 8'h00};
        st.ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        r.ph_code = OUT_FIXED;
        st.left = st.left + {9'd0, b};
        st.ph = PH_FLAG1;
      end
      PH_FLAG1, PH_FLAG2: begin
        r.ph_code = OUT_FIXED;
        if (length_spent(st)) begin
          r.pkt_end = 1'b1;
          st.ph = PH_HUNT;
        end else begin
          st.ph = (st.ph == PH_FLAG1) ? PH_FLAG2 : PH_OPTLEN;
        end
      end
      PH_OPTLEN: begin
        r.ph_code = OUT_FIXED;
        st.opt_left = b;
        st.opt_idx = '0;
        st.pts_flag = (b != 0);
        if (length_spent(st)) begin
          r.pkt_end = 1'b1;
          st.ph = PH_HUNT;
        end else begin
          st.ph = (b != 0) ? PH_OPT : PH_DATA;
        end
      end
      PH_OPT: begin
        r.ph_code = OUT_OPT;
        // bytes past the fifth are counted but dropped
        if (st.opt_idx < PTS_STORE) begin
          st.pts[st.opt_idx] = b;
          st.opt_idx = st.opt_idx + 3'd1;
        end
        st.opt_left = st.opt_left - 8'd1;
        if (length_spent(st)) begin
          r.pkt_end = 1'b1;
          st.ph = PH_HUNT;
        end else if (st.opt_left == 0) begin
          st.ph = PH_DATA;
        end
      end
      PH_DATA: begin
        r.ph_code = OUT_DATA;
        r.pay_byte = b;
        r.pay_valid = 1'b1;
        if (length_spent(st)) begin
          r.pkt_end = 1'b1;
          st.ph = PH_HUNT;
        end
      end
    endcase
    r.pts_flag = st.pts_flag;
    r.ticks = {st.pts[0][3:1], st.pts[1], st.pts[2][7:1], st.pts[3], st.pts[4][7:1]};
    r.ms = 27'(r.ticks / 33'd90);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < REPORT_LINES)
      $display("cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input byte_result_t want);
    if (payload_byte !== want.pay_byte)
      report_mismatch("payload_byte", payload_byte, want.pay_byte);
    if (payload_valid !== want.pay_valid)
      report_mismatch("payload_valid", payload_valid, want.pay_valid);
    if (packet_end !== want.pkt_end)
      report_mismatch("packet_end", packet_end, want.pkt_end);
    if (phase !== want.ph_code)
      report_mismatch("phase", phase, want.ph_code);
    if (pts_valid !== want.pts_flag)
      report_mismatch("pts_valid", pts_valid, want.pts_flag);
    if (pts_ticks !== want.ticks)
      report_mismatch("pts_ticks", pts_ticks, want.ticks);
    if (pts_ms !== want.ms)
      report_mismatch("pts_ms", pts_ms, want.ms);
  endtask

  // the generator runs its own copy of the parser to know what each byte means
  task automatic queue_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    void'(parse_stream_byte(gen_st, gen_lo, gen_hi, b));
    if (gen_st.ph != PH_HUNT)
      start_plan.delete();
  endtask

  task automatic queue_stream(input int count);
    logic [7:0]  b;
    logic [31:0] code;
    logic [63:0] span;
    logic [63:0] offset;
    int          r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      case (gen_st.ph)
        PH_HUNT: begin
          if (start_plan.size() == 0) begin
            if (gen_lo <= gen_hi && r < 80) begin
              span = {32'd0, gen_hi} - {32'd0, gen_lo} + 64'd1;
              offset = {32'd0, $urandom} % span;
              case ($urandom_range(0, 3))
                0: code = gen_lo;
                1: code = gen_hi;
                default: code = gen_lo + offset[31:0];
              endcase
            end else if (r < 90) begin
              // just outside the accepted range
              code = $urandom_range(0, 1) ? gen_lo - 32'd1 : gen_hi + 32'd1;
            end else begin
              code = $urandom;
            end
            for (int k = 3; k >= 0; k--)
              start_plan.push_back(code[8*k +: 8]);
          end
          b = start_plan.pop_front();
        end
        PH_LEN_HI: b = (r < 95) ? 8'd0 : (r < 99) ? 8'd1 : 8'd2;
        PH_LEN_LO: begin
          if (r < 15)
            b = $urandom_range(0, 3);
          else if (r < 80)
            b = $urandom_range(4, 40);
          else
            b = $urandom_range(0, 255);
        end
        PH_OPTLEN: begin
          if (r < 20)
            b = 8'd0;
          else if (r < 55)
            b = 8'd5;
          else if (r < 80)
            b = $urandom_range(1, 4);
          else if (r < 95)
            b = $urandom_range(6, 12);
          else
            b = $urandom_range(0, 255);
        end
        default: b = $urandom_range(0, 255);
      endcase
      queue_byte(b);
    end
  endtask

  // sampled at the rising edge, where the sender's queue and valid are settled
  task automatic wait_idle();
    do
      @(posedge clk);
    while (stream_bytes.size() != 0 || in_valid || parse_results_due.size() != 0);
    // pipeline is three stages deep
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do
      @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_ID_LOW)
      chk_lo = value;
    else
      chk_hi = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_with_range(input logic [31:0] lo, input logic [31:0] hi,
                                input int count);
    wait_idle();
    write_reg(CFG_ID_LOW, lo);
    write_reg(CFG_ID_HIGH, hi);
    gen_lo = lo;
    gen_hi = hi;
    queue_stream(count);
  endtask

  initial begin
    logic [31:0] lo_r;
    chk_st = '0;
    chk_st.ph = PH_HUNT;
    gen_st = chk_st;
    chk_lo = ID_LOW_RESET;
    chk_hi = ID_HIGH_RESET;
    gen_lo = ID_LOW_RESET;
    gen_hi = ID_HIGH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int k = 22; k >= 0; k--)
      queue_byte(OPENING[8*k +: 8]);
    queue_stream(100);

    run_with_range(32'h0000_01C0, 32'h0000_01EF, 80);
    run_with_range(32'h0000_0000, 32'hFFFF_FFFF, 60);
    run_with_range(32'hFFFF_FFFF, 32'h0000_0000, 40);
    run_with_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 60);
    run_with_range(32'h0000_0000, 32'h0000_0000, 60);
    lo_r = $urandom;
    run_with_range(lo_r, (lo_r > 32'hFFFF_FF00) ? 32'hFFFF_FFFF :
                         lo_r + $urandom_range(0, 255), 80);
    run_with_range(ID_LOW_RESET, ID_HIGH_RESET, 100);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // sender: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (stream_bytes.size() != 0) begin
        in_valid <= 1'b1;
        data_byte <= stream_bytes.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: free stretches alternate with short or long stalls
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_left == 0) begin
        receiver_busy = !receiver_busy;
        if (receiver_busy)
          hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24)
                                                 : $urandom_range(0, 3);
        else
          hold_left = $urandom_range(1, 30);
      end
      out_stall <= receiver_busy && hold_left != 0;
      if (hold_left != 0)
        hold_left--;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      byte_taken <= in_valid && !in_stall && !rst;
      if (!rst) begin
        if (in_valid && !in_stall)
          parse_results_due.push_back(parse_stream_byte(chk_st, chk_lo, chk_hi, data_byte));
        if (out_valid && !out_stall) begin
          if (parse_results_due.size() == 0)
            report_mismatch("unrequested result, payload_byte", payload_byte, 0);
          else
            check_result(parse_results_due.pop_front());
        end
      end
    end
  end

endmodule
